// ===== src/triangle_quadrature_point_mapping_assert.svh =====
// Assertion macros shared by the quadrature mapping RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef TRIANGLE_QUADRATURE_POINT_MAPPING_ASSERT_SVH
`define TRIANGLE_QUADRATURE_POINT_MAPPING_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TQPM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TQPM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define TQPM_ASSERT(label, clk, rst_n, prop, msg)
`define TQPM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/tqpm_pkg.sv =====
// Shared types, constants and reference point table for the quadrature mapping.
// No dependencies.
package tqpm_pkg;
	localparam int WQ = 30;
	localparam int TAB_N = 21;
	localparam int N_DERIV = 6;
	localparam logic [2:0] QORDER_RESET = 3'd1;

	typedef logic signed [31:0] qval_t;
	typedef struct packed {
		qval_t w;
		qval_t xi;
		qval_t eta;
	} qpoint_t;

	// Divider item tag
	typedef struct packed {
		logic vld;
		logic neg;
		logic deg;
		logic last;
	} dtag_t;

	localparam qpoint_t QTAB [TAB_N] = '{
		'{32'sd536870912, 32'sd357913941, 32'sd357913941},
		'{32'sd178956971, 32'sd178956971, 32'sd178956971},
		'{32'sd178956971, 32'sd715827883, 32'sd178956971},
		'{32'sd178956971, 32'sd178956971, 32'sd715827883},
		'{-32'sd301989888, 32'sd357913941, 32'sd357913941},
		'{32'sd279620267, 32'sd214748365, 32'sd644245094},
		'{32'sd279620267, 32'sd214748365, 32'sd214748365},
		'{32'sd279620267, 32'sd644245094, 32'sd214748365},
		'{32'sd119927078, 32'sd478833546, 32'sd478833546},
		'{32'sd119927078, 32'sd478833546, 32'sd116074732},
		'{32'sd119927078, 32'sd116074732, 32'sd478833546},
		'{32'sd59029893, 32'sd98329211, 32'sd98329211},
		'{32'sd59029893, 32'sd98329211, 32'sd877083403},
		'{32'sd59029893, 32'sd877083403, 32'sd98329211},
		'{32'sd120795955, 32'sd357913941, 32'sd357913941},
		'{32'sd71078570, 32'sd504811197, 32'sd504811197},
		'{32'sd71078570, 32'sd504811197, 32'sd64119429},
		'{32'sd71078570, 32'sd64119429, 32'sd504811197},
		'{32'sd67613083, 32'sd108755559, 32'sd108755559},
		'{32'sd67613083, 32'sd108755559, 32'sd856230706},
		'{32'sd67613083, 32'sd856230706, 32'sd108755559}
	};

	function automatic logic [4:0] qstart(input logic [2:0] order);
		logic [4:0] r;
		unique case (order)
			3'd2: r = 5'd1;
			3'd3: r = 5'd4;
			3'd4: r = 5'd8;
			3'd5: r = 5'd14;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] qcount(input logic [2:0] order);
		logic [2:0] r;
		unique case (order)
			3'd1: r = 3'd1;
			3'd2: r = 3'd3;
			3'd3: r = 3'd4;
			3'd4: r = 3'd6;
			3'd5: r = 3'd7;
			default: r = 3'd0;
		endcase
		return r;
	endfunction
endpackage

// ===== src/tqpm_if.sv =====
// Handshake channels of the quadrature mapping: triangle in, point out, config.
// Depends on nothing.
interface tqpm_tri_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] vertex0_x;
	logic signed [COORD_WIDTH-1:0] vertex0_y;
	logic signed [COORD_WIDTH-1:0] vertex1_x;
	logic signed [COORD_WIDTH-1:0] vertex1_y;
	logic signed [COORD_WIDTH-1:0] vertex2_x;
	logic signed [COORD_WIDTH-1:0] vertex2_y;
	modport source(output valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x,
		vertex2_y, input ready);
	modport sink(input valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x,
		vertex2_y, output ready);
endinterface

interface tqpm_pt_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [63:0] point_weight;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [63:0] jacobian_det;
	logic signed [COORD_WIDTH-1:0] dn1_dx;
	logic signed [COORD_WIDTH-1:0] dn1_dy;
	logic signed [COORD_WIDTH-1:0] dn2_dx;
	logic signed [COORD_WIDTH-1:0] dn2_dy;
	logic signed [COORD_WIDTH-1:0] dn3_dx;
	logic signed [COORD_WIDTH-1:0] dn3_dy;
	logic degenerate;
	logic last_point;
	modport source(output valid, point_weight, point_x, point_y, jacobian_det, dn1_dx, dn1_dy,
		dn2_dx, dn2_dy, dn3_dx, dn3_dy, degenerate, last_point, input ready);
	modport sink(input valid, point_weight, point_x, point_y, jacobian_det, dn1_dx, dn1_dy,
		dn2_dx, dn2_dy, dn3_dx, dn3_dy, degenerate, last_point, output ready);
endinterface

interface tqpm_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] quad_order;
	modport source(output valid, quad_order, input ready);
	modport sink(input valid, quad_order, output ready);
endinterface

// ===== src/tqpm_queue.sv =====
// Small register FIFO with valid/ready on both sides.
// No dependencies.
module tqpm_queue #(
	parameter int WIDTH,
	parameter int DEPTH,
	localparam int AW = $clog2(DEPTH),
	localparam int CNTW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;
	logic push, pop;

	assign push_ready = cnt_q != CNTW'(DEPTH);
	assign pop_valid = cnt_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNTW'(push) - CNTW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end
endmodule

// ===== src/tqpm_div.sv =====
// Pipelined restoring divider for the shape-function derivatives, one quotient bit
// per stage, saturating to the coordinate width. Depends on tqpm_pkg.
`include "triangle_quadrature_point_mapping_assert.svh"
module tqpm_div import tqpm_pkg::*; #(
	parameter int COORD_WIDTH,
	parameter int FRAC_BITS,
	localparam int NUMW = COORD_WIDTH + 2,
	localparam int DW = 2 * COORD_WIDTH + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  dtag_t                         in_tag,
	input  logic signed [NUMW-1:0]        in_num,
	input  logic [DW-1:0]                 in_den,
	output dtag_t                         out_tag,
	output logic signed [COORD_WIDTH-1:0] out_q
);
	localparam int CW = COORD_WIDTH;
	localparam int NW = NUMW + 2 * FRAC_BITS;
	localparam int CMPW = (NW > DW + CW) ? NW : DW + CW;
	localparam logic [CW-1:0] QMAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] QMIN = {1'b1, {(CW - 1){1'b0}}};

	logic [NUMW-1:0] mag;
	logic [NW-1:0] nfull;
	logic ovf_c;

	dtag_t tag_s [CW + 1];
	logic ovf_s [CW + 1];
	logic [DW-1:0] rem_s [CW + 1];
	logic [CW-1:0] nlo_s [CW + 1];
	logic [CW-1:0] q_s [CW + 1];
	logic [DW-1:0] den_s [CW + 1];
	logic [DW-1:0] rem_n [CW];
	logic ge_n [CW];

	logic [CW-1:0] qf;
	logic big, bigneg;
	logic signed [CW-1:0] res;

	always_comb begin
		mag = in_num[NUMW-1] ? NUMW'(-in_num) : NUMW'(in_num);
		nfull = {mag, {(2 * FRAC_BITS){1'b0}}};
		// quotient needs more than CW bits
		ovf_c = CMPW'(nfull) >= (CMPW'(in_den) << CW);
	end

	always_comb begin
		for (int j = 0; j < CW; j++) begin
			logic [DW:0] trial;
			trial = {rem_s[j], nlo_s[j][CW-1]};
			ge_n[j] = trial >= {1'b0, den_s[j]};
			rem_n[j] = ge_n[j] ? DW'(trial - {1'b0, den_s[j]}) : DW'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= CW; j++) begin
				tag_s[j] <= '0;
			end
			out_tag <= '0;
		end else if (en) begin
			tag_s[0] <= in_tag;
			for (int j = 0; j < CW; j++) begin
				tag_s[j+1] <= tag_s[j];
			end
			out_tag <= tag_s[CW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= ovf_c;
			rem_s[0] <= DW'(nfull >> CW);
			nlo_s[0] <= nfull[CW-1:0];
			q_s[0] <= '0;
			den_s[0] <= in_den;
			for (int j = 0; j < CW; j++) begin
				ovf_s[j+1] <= ovf_s[j];
				rem_s[j+1] <= rem_n[j];
				nlo_s[j+1] <= nlo_s[j] << 1;
				q_s[j+1] <= {q_s[j][CW-2:0], ge_n[j]};
				den_s[j+1] <= den_s[j];
			end
			out_q <= res;
		end
	end

	always_comb begin
		qf = q_s[CW];
		big = ovf_s[CW] || qf[CW-1];
		bigneg = ovf_s[CW] || (qf[CW-1] && (|qf[CW-2:0]));
		if (tag_s[CW].deg) begin
			res = '0;
		end else if (!tag_s[CW].neg) begin
			res = big ? QMAX : qf;
		end else begin
			res = bigneg ? QMIN : -qf;
		end
	end

	`TQPM_ASSERT_IMPL(a_den_nonzero, clk, arst_n, en && in_tag.vld && !in_tag.deg, in_den != '0, "divider fed a zero denominator")
endmodule

// ===== src/tqpm_front.sv =====
// Front part: takes triangles, forms edges, determinant and derivative numerators,
// runs the six divisions and assembles one record per triangle. Depends on tqpm_pkg, tqpm_if, tqpm_div and tqpm_queue.
`include "triangle_quadrature_point_mapping_assert.svh"
module tqpm_front import tqpm_pkg::*; #(
	parameter int COORD_WIDTH,
	parameter int FRAC_BITS,
	localparam int RECW = 14 * COORD_WIDTH + 8
) (
	input  logic            clk,
	input  logic            arst_n,
	tqpm_tri_if.sink        tri_in,
	output logic            rec_valid,
	input  logic            rec_ready,
	output logic [RECW-1:0] rec_data
);
	localparam int CW = COORD_WIDTH;
	localparam int EW = CW + 1;
	localparam int DW = 2 * CW + 2;
	localparam int DTW = 2 * CW + 3;
	localparam int NUMW = CW + 2;
	localparam int SIDEW = 8 * CW + 8;
	localparam int SIDE_DEPTH = (CW + 2) / 6 + 3;

	logic v_s1, v_s2, v_s3;
	logic signed [CW-1:0] x0_s1, y0_s1, x0_s2, y0_s2;
	logic signed [EW-1:0] a_s1, b_s1, c_s1, d_s1, a_s2, b_s2, c_s2, d_s2;
	logic signed [DW-1:0] ad_s2, bc_s2;
	logic [2:0] idx_s3;
	logic signed [DTW-1:0] det_s3;
	logic [DW-1:0] den_s3;
	logic deg_s3;
	logic signed [NUMW-1:0] num_s3 [N_DERIV];

	logic signed [DTW-1:0] det_c;
	logic div_en, issue, iss_last, iss_free, load_s3, load_s2, accept;
	dtag_t din_tag, dout_tag;
	logic signed [CW-1:0] dout_q;
	logic signed [CW-1:0] ders_q [N_DERIV - 1];

	logic side_ready, side_valid;
	logic [SIDEW-1:0] side_in, side_out;

	assign det_c = DTW'(ad_s2) - DTW'(bc_s2);

	// hold the divider while a finished record cannot leave
	assign div_en = !(dout_tag.vld && dout_tag.last && !rec_ready);
	assign issue = v_s3 && div_en;
	assign iss_last = idx_s3 == 3'(N_DERIV - 1);
	assign iss_free = !v_s3 || (issue && iss_last);
	assign load_s3 = v_s2 && iss_free && side_ready;
	assign load_s2 = v_s1 && (!v_s2 || load_s3);
	assign tri_in.ready = !v_s1 || load_s2;
	assign accept = tri_in.valid && tri_in.ready;

	assign side_in = {x0_s2, y0_s2, a_s2, b_s2, c_s2, d_s2, det_c, det_c == '0};

	always_comb begin
		din_tag.vld = issue;
		din_tag.neg = num_s3[idx_s3][NUMW-1] ^ det_s3[DTW-1];
		din_tag.deg = deg_s3;
		din_tag.last = iss_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			idx_s3 <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (load_s2) begin
				v_s1 <= 1'b0;
			end
			if (load_s2) begin
				v_s2 <= 1'b1;
			end else if (load_s3) begin
				v_s2 <= 1'b0;
			end
			if (load_s3) begin
				v_s3 <= 1'b1;
				idx_s3 <= '0;
			end else if (issue) begin
				if (iss_last) begin
					v_s3 <= 1'b0;
				end
				idx_s3 <= iss_last ? '0 : idx_s3 + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x0_s1 <= tri_in.vertex0_x;
			y0_s1 <= tri_in.vertex0_y;
			a_s1 <= EW'(tri_in.vertex1_x) - EW'(tri_in.vertex0_x);
			b_s1 <= EW'(tri_in.vertex1_y) - EW'(tri_in.vertex0_y);
			c_s1 <= EW'(tri_in.vertex2_x) - EW'(tri_in.vertex0_x);
			d_s1 <= EW'(tri_in.vertex2_y) - EW'(tri_in.vertex0_y);
		end
		if (load_s2) begin
			x0_s2 <= x0_s1;
			y0_s2 <= y0_s1;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			c_s2 <= c_s1;
			d_s2 <= d_s1;
			ad_s2 <= a_s1 * d_s1;
			bc_s2 <= b_s1 * c_s1;
		end
		if (load_s3) begin
			det_s3 <= det_c;
			den_s3 <= DW'(det_c[DTW-1] ? -det_c : det_c);
			deg_s3 <= det_c == '0;
			num_s3[0] <= NUMW'(b_s2) - NUMW'(d_s2);
			num_s3[1] <= NUMW'(c_s2) - NUMW'(a_s2);
			num_s3[2] <= NUMW'(d_s2);
			num_s3[3] <= -NUMW'(c_s2);
			num_s3[4] <= -NUMW'(b_s2);
			num_s3[5] <= NUMW'(a_s2);
		end
		// collect quotients in issue order
		if (div_en && dout_tag.vld && !dout_tag.last) begin
			for (int j = 0; j < N_DERIV - 2; j++) begin
				ders_q[j] <= ders_q[j+1];
			end
			ders_q[N_DERIV-2] <= dout_q;
		end
	end

	tqpm_div #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(div_en),
		.in_tag(din_tag),
		.in_num(num_s3[idx_s3]),
		.in_den(den_s3),
		.out_tag(dout_tag),
		.out_q(dout_q)
	);

	tqpm_queue #(
		.WIDTH(SIDEW),
		.DEPTH(SIDE_DEPTH)
	) u_side (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(load_s3),
		.push_ready(side_ready),
		.push_data(side_in),
		.pop_valid(side_valid),
		.pop_ready(rec_valid && rec_ready),
		.pop_data(side_out)
	);

	assign rec_valid = dout_tag.vld && dout_tag.last;
	assign rec_data = {side_out, ders_q[0], ders_q[1], ders_q[2], ders_q[3], ders_q[4], dout_q};

	`TQPM_ASSERT_IMPL(a_side_present, clk, arst_n, rec_valid, side_valid, "last quotient without a triangle record")
endmodule

// ===== src/tqpm_back.sv =====
// Back part: walks the reference points of one triangle record and emits the
// scaled weight, mapped point and derivatives per point. Depends on tqpm_pkg and tqpm_if.
`include "triangle_quadrature_point_mapping_assert.svh"
module tqpm_back import tqpm_pkg::*; #(
	parameter int COORD_WIDTH,
	localparam int RECW = 14 * COORD_WIDTH + 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [2:0]      quad_order,
	input  logic            rec_valid,
	output logic            rec_ready,
	input  logic [RECW-1:0] rec_data,
	tqpm_pt_if.source       pt_out
);
	localparam int CW = COORD_WIDTH;
	localparam int EW = CW + 1;
	localparam int DTW = 2 * CW + 3;
	localparam int LB = CW + 1;
	localparam int HB = DTW - LB;
	localparam int MW = EW + 32;
	localparam int PW = CW + 34;
	localparam int WW = DTW + 32;
	localparam int SW = WW - WQ;
	localparam int WBIG = (SW > 64) ? SW : 65;
	localparam int DBIG = (DTW > 64) ? DTW : 65;
	localparam logic signed [PW-1:0] PRND = PW'(1) << (WQ - 1);
	localparam logic signed [WW-1:0] WRND = WW'(1) << (WQ - 1);
	localparam logic [CW-1:0] PMAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] PMIN = {1'b1, {(CW - 1){1'b0}}};
	localparam logic [63:0] LMAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] LMIN = {1'b1, {63{1'b0}}};

	logic signed [CW-1:0] r_x0, r_y0;
	logic signed [EW-1:0] r_a, r_b, r_c, r_d;
	logic signed [DTW-1:0] r_det;
	logic r_deg;
	logic signed [CW-1:0] r_ders [N_DERIV];

	logic [2:0] cnt, k_q;
	logic [4:0] st;
	logic en, issue, pt_last;
	qpoint_t qe;

	logic v_s1, last_s1, deg_s1, v_s2, last_s2, deg_s2;
	logic signed [CW-1:0] x0_s1, y0_s1;
	logic signed [DTW-1:0] det_s1, det_s2;
	logic signed [CW-1:0] ders_s1 [N_DERIV];
	logic signed [CW-1:0] ders_s2 [N_DERIV];
	logic signed [MW-1:0] axi_s1, ceta_s1, bxi_s1, deta_s1;
	logic signed [LB+32:0] wlo_s1;
	logic signed [HB+31:0] whi_s1;
	logic signed [PW-1:0] px_s2, py_s2;
	logic signed [WW-1:0] wd_s2;

	logic signed [PW-1:0] pxr, pyr;
	logic signed [CW+3:0] pxs, pys;
	logic signed [WW-1:0] wr;
	logic signed [SW-1:0] wsh;
	logic signed [WBIG-1:0] wext;
	logic signed [DBIG-1:0] dext;
	logic [CW-1:0] px_sat, py_sat;
	logic [63:0] w_sat, d_sat;

	assign {r_x0, r_y0, r_a, r_b, r_c, r_d, r_det, r_deg, r_ders[0], r_ders[1], r_ders[2],
		r_ders[3], r_ders[4], r_ders[5]} = rec_data;

	assign cnt = qcount(quad_order);
	assign st = qstart(quad_order);
	assign en = !pt_out.valid || pt_out.ready;
	assign pt_last = k_q == cnt - 3'd1;
	assign issue = en && rec_valid && (cnt != '0);
	// release the record with its last point, or at once when the order has none
	assign rec_ready = en && rec_valid && ((cnt == '0) || pt_last);
	assign qe = QTAB[st + 5'(k_q)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			pt_out.valid <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= pt_last ? '0 : k_q + 1'b1;
			end
			if (en) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				pt_out.valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= pt_last;
			deg_s1 <= r_deg;
			x0_s1 <= r_x0;
			y0_s1 <= r_y0;
			det_s1 <= r_det;
			ders_s1 <= r_ders;
			axi_s1 <= r_a * qe.xi;
			ceta_s1 <= r_c * qe.eta;
			bxi_s1 <= r_b * qe.xi;
			deta_s1 <= r_d * qe.eta;
			// weight times determinant in two partial products
			wlo_s1 <= $signed({1'b0, r_det[LB-1:0]}) * qe.w;
			whi_s1 <= $signed(r_det[DTW-1:LB]) * qe.w;

			last_s2 <= last_s1;
			deg_s2 <= deg_s1;
			det_s2 <= det_s1;
			ders_s2 <= ders_s1;
			px_s2 <= (PW'(x0_s1) <<< WQ) + PW'(axi_s1) + PW'(ceta_s1);
			py_s2 <= (PW'(y0_s1) <<< WQ) + PW'(bxi_s1) + PW'(deta_s1);
			wd_s2 <= (WW'(whi_s1) <<< LB) + WW'(wlo_s1);

			pt_out.point_weight <= w_sat;
			pt_out.point_x <= px_sat;
			pt_out.point_y <= py_sat;
			pt_out.jacobian_det <= d_sat;
			pt_out.dn1_dx <= ders_s2[0];
			pt_out.dn1_dy <= ders_s2[1];
			pt_out.dn2_dx <= ders_s2[2];
			pt_out.dn2_dy <= ders_s2[3];
			pt_out.dn3_dx <= ders_s2[4];
			pt_out.dn3_dy <= ders_s2[5];
			pt_out.degenerate <= deg_s2;
			pt_out.last_point <= last_s2;
		end
	end

	// round half up, drop the table fraction, saturate
	always_comb begin
		pxr = px_s2 + PRND;
		pyr = py_s2 + PRND;
		pxs = $signed(pxr[PW-1:WQ]);
		pys = $signed(pyr[PW-1:WQ]);
		px_sat = (pxs[CW+3:CW-1] == {5{pxs[CW-1]}}) ? pxs[CW-1:0] : (pxs[CW+3] ? PMIN : PMAX);
		py_sat = (pys[CW+3:CW-1] == {5{pys[CW-1]}}) ? pys[CW-1:0] : (pys[CW+3] ? PMIN : PMAX);
		wr = wd_s2 + WRND;
		wsh = $signed(wr[WW-1:WQ]);
		wext = WBIG'(wsh);
		w_sat = (wext[WBIG-1:63] == {(WBIG - 63){wext[63]}}) ? wext[63:0] :
			(wext[WBIG-1] ? LMIN : LMAX);
		dext = DBIG'(det_s2);
		d_sat = (dext[DBIG-1:63] == {(DBIG - 63){dext[63]}}) ? dext[63:0] :
			(dext[DBIG-1] ? LMIN : LMAX);
	end

	`TQPM_ASSERT_IMPL(a_deg_ders, clk, arst_n, pt_out.valid && pt_out.degenerate, (pt_out.dn1_dx == 0) && (pt_out.dn1_dy == 0) && (pt_out.dn2_dx == 0) && (pt_out.dn2_dy == 0) && (pt_out.dn3_dx == 0) && (pt_out.dn3_dy == 0), "degenerate point with nonzero derivative")
	`TQPM_ASSERT_IMPL(a_deg_det, clk, arst_n, pt_out.valid && pt_out.degenerate, (pt_out.jacobian_det == 0) && (pt_out.point_weight == 0), "degenerate flag with nonzero determinant")
endmodule

// ===== src/triangle_quadrature_point_mapping.sv =====
// Path from triangle to first point: three front stages, six issue slots into the
// bit-per-stage divider, its output register, queue, three back stages.
// Throughput: the divider takes the six derivatives of each triangle in turn; one point per
// cycle out while pt_out is ready; with order 5 the seven points set the pace.
// Reset: arst_n clears all valid state and sets quad_order to 1; no clearing pass.
module triangle_quadrature_point_mapping import tqpm_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	tqpm_cfg_if.sink   cfg,
	tqpm_tri_if.sink   tri_in,
	tqpm_pt_if.source  pt_out
);
	localparam int RECW = 14 * COORD_WIDTH + 8;
	localparam int QDEPTH = 4;

	logic [2:0] quad_order_q;
	logic f_valid, f_ready, b_valid, b_ready;
	logic [RECW-1:0] f_data, b_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_order_q <= QORDER_RESET;
		end else if (cfg.valid) begin
			quad_order_q <= cfg.quad_order;
		end
	end

	tqpm_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.tri_in(tri_in),
		.rec_valid(f_valid),
		.rec_ready(f_ready),
		.rec_data(f_data)
	);

	tqpm_queue #(
		.WIDTH(RECW),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data(f_data),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.pop_data(b_data)
	);

	tqpm_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.quad_order(quad_order_q),
		.rec_valid(b_valid),
		.rec_ready(b_ready),
		.rec_data(b_data),
		.pt_out(pt_out)
	);
endmodule

// ===== tb/sv/tb_triangle_quadrature_point_mapping.sv =====
`timescale 1ns / 1ps
// Testbench of the triangle quadrature mapping: drives triangles and the order register,
// predicts every quadrature point and checks it field by field. Uses tqpm_pkg and tqpm_if.
module tb_triangle_quadrature_point_mapping;
	import tqpm_pkg::*;

	typedef struct {
		logic signed [63:0] weight;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [63:0] det;
		logic signed [31:0] dn [6];
		logic deg;
		logic last;
	} qpt_t;

	logic clk;
	logic arst_n;
	tqpm_cfg_if cfg();
	tqpm_tri_if #(.COORD_WIDTH(32)) tri_in();
	tqpm_pt_if #(.COORD_WIDTH(32)) pt_out();

	triangle_quadrature_point_mapping #(.COORD_WIDTH(32), .FRAC_BITS(16)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg(cfg.sink), .tri_in(tri_in.sink), .pt_out(pt_out.source)
	);

	qpt_t expected_pts[$];
	logic [2:0] order_now;
	int errors;
	int n_tri;
	int n_pts;
	int n_deg;
	int hold_cycles;
	longint cycle;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle > 400000) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic logic signed [31:0] sat32(logic signed [127:0] v);
		if (v > 128'sh7fffffff)
			return 32'sh7fffffff;
		if (v < -128'sh80000000)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] sat64(logic signed [127:0] v);
		if (v > 128'sh7fffffffffffffff)
			return 64'sh7fffffffffffffff;
		if (v < -128'sh8000000000000000)
			return 64'sh8000000000000000;
		return v[63:0];
	endfunction

	function automatic logic signed [127:0] round30(logic signed [127:0] v);
		return (v + (128'sd1 <<< 29)) >>> WQ;
	endfunction

	// Quotient truncated toward zero, as SV signed division does.
	function automatic logic signed [31:0] slope(logic signed [127:0] num,
			logic signed [127:0] det);
		return sat32((num <<< 32) / det);
	endfunction

	task automatic predict_points(logic signed [31:0] v [6]);
		logic signed [127:0] x0, y0, a, b, c, d, det, w, xi, eta;
		logic signed [31:0] dn [6];
		logic deg;
		int cnt;
		int st;
		qpt_t p;
		x0 = v[0];
		y0 = v[1];
		a = 128'(v[2]) - x0;
		b = 128'(v[3]) - y0;
		c = 128'(v[4]) - x0;
		d = 128'(v[5]) - y0;
		det = a * d - b * c;
		deg = (det == 0);
		foreach (dn[j])
			dn[j] = '0;
		if (!deg) begin
			dn[0] = slope(b - d, det);
			dn[1] = slope(c - a, det);
			dn[2] = slope(d, det);
			dn[3] = slope(-c, det);
			dn[4] = slope(-b, det);
			dn[5] = slope(a, det);
		end
		cnt = qcount(order_now);
		st = qstart(order_now);
		if (deg)
			n_deg++;
		for (int k = 0; k < cnt; k++) begin
			w = QTAB[st + k].w;
			xi = QTAB[st + k].xi;
			eta = QTAB[st + k].eta;
			p.weight = sat64(round30(det * w));
			p.px = sat32(round30((x0 <<< WQ) + xi * a + eta * c));
			p.py = sat32(round30((y0 <<< WQ) + xi * b + eta * d));
			p.det = sat64(det);
			p.dn = dn;
			p.deg = deg;
			p.last = (k + 1 == cnt);
			expected_pts.insert(expected_pts.size(), p);
		end
	endtask

	// Offer one item; valid stays up after acceptance so the next item can follow at once.
	task automatic send_triangle(logic signed [31:0] v [6]);
		int idle;
		idle = $urandom_range(0, 6);
		@(negedge clk);
		if (idle > 0) begin
			tri_in.valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		tri_in.valid <= 1'b1;
		tri_in.vertex0_x <= v[0];
		tri_in.vertex0_y <= v[1];
		tri_in.vertex1_x <= v[2];
		tri_in.vertex1_y <= v[3];
		tri_in.vertex2_x <= v[4];
		tri_in.vertex2_y <= v[5];
		do
			@(posedge clk);
		while (!tri_in.ready);
		predict_points(v);
		n_tri++;
	endtask

	task automatic stop_input();
		@(negedge clk);
		tri_in.valid <= 1'b0;
	endtask

	// Let the block drain before a register write; order 0 triangles leave nothing to wait on.
	task automatic write_order(logic [2:0] ord);
		stop_input();
		wait (expected_pts.size() == 0);
		repeat (80) @(negedge clk);
		cfg.valid <= 1'b1;
		cfg.quad_order <= ord;
		do
			@(posedge clk);
		while (!cfg.ready);
		order_now = ord;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'sh7fffffff - $urandom_range(0, 3);
			2: return 32'sh80000000 + $urandom_range(0, 3);
			3: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
		endcase
	endfunction

	task automatic send_random(int n);
		logic signed [31:0] v [6];
		repeat (n) begin
			foreach (v[j])
				v[j] = rand_coord();
			// collinear case now and then
			if ($urandom_range(0, 9) == 0) begin
				v[2] = v[0] + 32'sh10000;
				v[3] = v[1] + 32'sh20000;
				v[4] = v[0] + 32'sh20000;
				v[5] = v[1] + 32'sh40000;
			end
			send_triangle(v);
		end
	endtask

	task automatic test_directed();
		logic signed [31:0] v [6];
		v = '{0, 0, 32'sh10000, 0, 0, 32'sh10000};
		for (int o = 0; o < 8; o++) begin
			write_order(3'(o));
			send_triangle(v);
		end
		write_order(3'd5);
		v = '{0, 0, 32'sh10000, 0, 0, 32'sh10000};
		send_triangle(v);
		v = '{0, 0, 32'sh10000, 0, 32'sh20000, 0};
		send_triangle(v);
		v = '{5, 5, 5, 5, 5, 5};
		send_triangle(v);
		v = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000};
		send_triangle(v);
		v = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff};
		send_triangle(v);
		v = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0, 0};
		send_triangle(v);
		v = '{0, 0, 1, 0, 0, 1};
		send_triangle(v);
		v = '{0, 0, 32'sh7fffffff, 1, 32'sh7fffffff, 2};
		send_triangle(v);
		v = '{-1, -1, 32'shffff0000, 32'shfffe0000, 32'sh0003_0000, 32'shfff0_0000};
		send_triangle(v);
	endtask

	task automatic test_backpressure();
		write_order(3'd5);
		hold_cycles = 300;
		send_random(30);
	endtask

	task automatic test_random_orders();
		logic [2:0] seq [7] = '{3'd1, 3'd3, 3'd0, 3'd4, 3'd2, 3'd7, 3'd5};
		foreach (seq[i]) begin
			write_order(seq[i]);
			send_random(16);
		end
	endtask

	// Receiver: a random wait before each item, plus one long hold-off on request.
	initial begin
		int gap;
		pt_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = $urandom_range(0, 6);
			if (hold_cycles > 0) begin
				gap = hold_cycles;
				hold_cycles = 0;
			end
			if (gap > 0) begin
				pt_out.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pt_out.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(pt_out.valid && pt_out.ready));
		end
	end

	initial begin
		qpt_t e;
		forever begin
			@(posedge clk);
			if (arst_n && pt_out.valid && pt_out.ready) begin
				n_pts++;
				if (expected_pts.size() == 0) begin
					$error("point with no expectation");
					errors++;
				end else begin
					e = expected_pts.pop_front();
					if (pt_out.point_weight !== e.weight) begin
						$error("point_weight exp %0d got %0d", e.weight, pt_out.point_weight);
						errors++;
					end
					if (pt_out.point_x !== e.px) begin
						$error("point_x exp %0d got %0d", e.px, pt_out.point_x);
						errors++;
					end
					if (pt_out.point_y !== e.py) begin
						$error("point_y exp %0d got %0d", e.py, pt_out.point_y);
						errors++;
					end
					if (pt_out.jacobian_det !== e.det) begin
						$error("jacobian_det exp %0d got %0d", e.det, pt_out.jacobian_det);
						errors++;
					end
					if (pt_out.dn1_dx !== e.dn[0]) begin
						$error("dn1_dx exp %0d got %0d", e.dn[0], pt_out.dn1_dx);
						errors++;
					end
					if (pt_out.dn1_dy !== e.dn[1]) begin
						$error("dn1_dy exp %0d got %0d", e.dn[1], pt_out.dn1_dy);
						errors++;
					end
					if (pt_out.dn2_dx !== e.dn[2]) begin
						$error("dn2_dx exp %0d got %0d", e.dn[2], pt_out.dn2_dx);
						errors++;
					end
					if (pt_out.dn2_dy !== e.dn[3]) begin
						$error("dn2_dy exp %0d got %0d", e.dn[3], pt_out.dn2_dy);
						errors++;
					end
					if (pt_out.dn3_dx !== e.dn[4]) begin
						$error("dn3_dx exp %0d got %0d", e.dn[4], pt_out.dn3_dx);
						errors++;
					end
					if (pt_out.dn3_dy !== e.dn[5]) begin
						$error("dn3_dy exp %0d got %0d", e.dn[5], pt_out.dn3_dy);
						errors++;
					end
					if (pt_out.degenerate !== e.deg) begin
						$error("degenerate exp %0b got %0b", e.deg, pt_out.degenerate);
						errors++;
					end
					if (pt_out.last_point !== e.last) begin
						$error("last_point exp %0b got %0b", e.last, pt_out.last_point);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		errors = 0;
		n_tri = 0;
		n_pts = 0;
		n_deg = 0;
		hold_cycles = 0;
		order_now = QORDER_RESET;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.quad_order = '0;
		tri_in.valid = 1'b0;
		tri_in.vertex0_x = '0;
		tri_in.vertex0_y = '0;
		tri_in.vertex1_x = '0;
		tri_in.vertex1_y = '0;
		tri_in.vertex2_x = '0;
		tri_in.vertex2_y = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random_orders();
		stop_input();
		wait (expected_pts.size() == 0);
		repeat (100) @(negedge clk);
		$display("Sent %0d triangles over orders 0..7, %0d degenerate; checked %0d points.",
			n_tri, n_deg, n_pts);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
